// ----- rtl/core/kdd_pkg.sv -----
// ----------------------------------------------------------------------------
// kdd_pkg
// Shared types, phase codes and key decode table for the keypad scanner.
// ----------------------------------------------------------------------------
package kdd_pkg;

  localparam int unsigned CodeW  = 8;
  localparam int unsigned KeyW   = 5;
  localparam int unsigned TicksW = 8;

  localparam logic [1:0] PH_CAPTURE = 2'd0;
  localparam logic [1:0] PH_CONFIRM = 2'd1;
  localparam logic [1:0] PH_WAIT    = 2'd2;

  localparam logic [CodeW-1:0]  POWER_CODE   = 8'h1E;
  localparam logic [TicksW-1:0] TICKS_MAX    = 8'hFF;
  localparam logic [TicksW-1:0] POFF_DEFAULT = 8'd40;

  typedef struct packed {
    logic [1:0]        phase;
    logic [CodeW-1:0]  held_code;
    logic [TicksW-1:0] power_ticks;
    logic [KeyW-1:0]   last_key;
    logic              tick_running;
  } kdd_state_t;

  typedef struct packed {
    logic              tick_enable;
    logic              power_off;
    logic              key_pressed;
    logic [KeyW-1:0]   key_code;
  } kdd_result_t;

  function automatic logic [KeyW-1:0] decode_key(input logic [CodeW-1:0] code,
                                                 input logic [KeyW-1:0]  prev);
    logic [KeyW-1:0] k;
    case (code)
      8'h4D:   k = 5'd1;
      8'h2D:   k = 5'd2;
      8'h1D:   k = 5'd3;
      8'h4B:   k = 5'd4;
      8'h2B:   k = 5'd5;
      8'h1B:   k = 5'd6;
      8'h87:   k = 5'd7;
      8'h47:   k = 5'd8;
      8'h27:   k = 5'd9;
      8'h1E:   k = 5'd11;
      8'h8B:   k = 5'd12;
      8'h4E:   k = 5'd13;
      8'h8E:   k = 5'd14;
      8'h8D:   k = 5'd15;
      8'h17:   k = 5'd16;
      default: k = prev;
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/core/kdd_step.sv -----
// ----------------------------------------------------------------------------
// kdd_step
// Next-state and result logic for one scan event.
// ----------------------------------------------------------------------------
module kdd_step (
  input  kdd_pkg::kdd_state_t          st,
  input  logic                         run_request,
  input  logic [3:0]                   row_lines,
  input  logic [3:0]                   column_lines,
  input  logic                         power_low,
  input  logic [kdd_pkg::TicksW-1:0]   power_off_ticks,
  output kdd_pkg::kdd_state_t          st_next,
  output kdd_pkg::kdd_result_t         res
);
  import kdd_pkg::*;

  logic [CodeW-1:0]  code;
  logic              can_count;
  logic [TicksW-1:0] ticks_inc;
  logic              pressed;
  logic              poff;

  assign code      = power_low ? POWER_CODE : {column_lines, row_lines};
  assign can_count = power_low && (st.power_ticks != TICKS_MAX);
  assign ticks_inc = st.power_ticks + TicksW'(1);

  always_comb begin
    st_next = st;
    pressed = 1'b0;
    poff    = 1'b0;
    if (run_request) begin
      case (st.phase)
        PH_CAPTURE: begin
          st_next.held_code    = code;
          if (power_low) begin
            st_next.power_ticks = '0;
          end
          st_next.phase        = PH_CONFIRM;
          st_next.tick_running = 1'b1;
        end
        PH_CONFIRM: begin
          if (can_count) begin
            st_next.power_ticks = ticks_inc;
          end
          if (code == st.held_code) begin
            st_next.phase = PH_WAIT;
          end else begin
            st_next.phase        = PH_CAPTURE;
            st_next.held_code    = '0;
            st_next.tick_running = 1'b0;
          end
        end
        PH_WAIT: begin
          if (can_count) begin
            st_next.power_ticks = ticks_inc;
            poff = (ticks_inc == power_off_ticks);
          end
          if (code != st.held_code) begin
            st_next.last_key     = decode_key(st.held_code, st.last_key);
            pressed              = 1'b1;
            st_next.phase        = PH_CAPTURE;
            st_next.held_code    = '0;
            st_next.tick_running = 1'b0;
          end
        end
        default: begin
          st_next.phase     = PH_CAPTURE;
          st_next.last_key  = '0;
          st_next.held_code = '0;
        end
      endcase
    end
  end

  assign res.key_code    = st_next.last_key;
  assign res.key_pressed = pressed;
  assign res.power_off   = poff;
  assign res.tick_enable = st_next.tick_running;

endmodule

// ----- rtl/core/keypad_debounce_decoder.sv -----
// ----------------------------------------------------------------------------
// keypad_debounce_decoder
// Matrix keypad scanner with debounce and power-key hold timer.
//
//   channel  dir  handshake                 payload
//   s_axis   in   s_tvalid / s_tready       s_tdata  (scan event)
//   m_axis   out  m_tvalid / m_tready       m_tdata  (result word)
//   cfg      in   cfg_valid / cfg_ready     cfg_data (power_off_ticks)
//
// One word per cycle while s_tready is high; result is registered and appears in the cycle after acceptance.
// Scan state updates at acceptance; result register decouples the sides.
// s_tready drops only while a result waits and m_tready is low.
// cfg_ready is always high. Synchronous reset clears state, threshold = 40.
// ----------------------------------------------------------------------------
module keypad_debounce_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // run_request, row_lines[3:0], column_lines[3:0], power_low
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // key_code[4:0], key_pressed, power_off, tick_enable
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import kdd_pkg::*;

  kdd_state_t        st;
  kdd_state_t        st_next;
  kdd_result_t       res;
  kdd_result_t       res_q;
  logic [TicksW-1:0] power_off_ticks;
  logic              s_fire;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign s_fire    = s_tvalid && s_tready;

  kdd_step u_step (
    .st              (st),
    .run_request     (s_tdata[0]),
    .row_lines       (s_tdata[4:1]),
    .column_lines    (s_tdata[8:5]),
    .power_low       (s_tdata[9]),
    .power_off_ticks (power_off_ticks),
    .st_next         (st_next),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st              <= '0;
      power_off_ticks <= POFF_DEFAULT;
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        power_off_ticks <= cfg_data;
      end
      if (s_fire) begin
        st       <= st_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      res_q <= res;
    end
  end

  assign m_tdata = res_q;

endmodule

// ----- rtl/core/kdd_checker.sv -----
// ----------------------------------------------------------------------------
// kdd_checker
// Port-level checks for the keypad scanner, bound to the top level.
// ----------------------------------------------------------------------------
module kdd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata
);

  // a press ends the run, so the tick stops with it
  a_press_stops_tick: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[5] |-> !m_tdata[7])
    else $error("key_pressed with tick_enable set");

  // empty result register never blocks input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // accepted word shows up next cycle
  a_accept_to_valid: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted word produced no result");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("m_tvalid dropped while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("m_tdata changed while stalled");

endmodule

bind keypad_debounce_decoder kdd_checker u_kdd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
